[rtl/dau_pkg.sv]
// ----------------------------------------------------------------------------
// dau_pkg
// Shared types, codes and calendar tables of the date arithmetic unit.
// ----------------------------------------------------------------------------
package dau_pkg;

	localparam int KIND_W   = 2;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int WD_W     = 3;
	localparam int STATUS_W = 2;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int YEAR_MAX_DEF    = 9999;

	localparam logic [KIND_W-1:0] KIND_DAYS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MONTHS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_YEARS  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_DATE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Remainder register width and divisors of the shared divider.
	localparam int REM_W = 8;
	localparam logic [REM_W-2:0] DIVISOR_CENTURY = 7'd100;
	localparam logic [REM_W-2:0] DIVISOR_MONTHS  = 7'd12;
	localparam logic [REM_W-2:0] DIVISOR_WEEK    = 7'd7;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_BAD,
		OP_RANGE,
		OP_YEARS,
		OP_DIV_MON,
		OP_MONS,
		OP_DIV_YEAR,
		OP_CLAMP,
		OP_WALK,
		OP_DIV_WDY,
		OP_DIV_SUM,
		OP_WD,
		OP_PUB
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VDIV,
		ST_CHECK,
		ST_WALK,
		ST_MDIV,
		ST_NDIV0,
		ST_NDIV,
		ST_CLAMP,
		ST_WDIV0,
		ST_WDIV,
		ST_SDIV,
		ST_PUB
	} ctl_state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic              div_busy;
		logic              date_ok;
		logic              mon_bad;
		logic              yr_bad;
		logic              ny_bad;
		logic              n_zero;
		logic [KIND_W-1:0] kind;
	} dp_stat_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [DAY_W-1:0] len;
		if (month == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	// floor(2.6*m' - 0.2) where m' counts from March, indexed by calendar month.
	function automatic logic [DAY_W-1:0] zeller_term(input logic [MONTH_W-1:0] month);
		logic [DAY_W-1:0] t;
		case (month)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

[rtl/dau_dp.sv]
// ----------------------------------------------------------------------------
// dau_dp
// Datapath: date registers, month walker, range checks and a shared
// divider by small constants built on reciprocal multiplication.
// ----------------------------------------------------------------------------
module dau_dp #(
	parameter int OFFSET_BITS = dau_pkg::OFFSET_BITS_DEF,
	parameter int YEAR_MAX    = dau_pkg::YEAR_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dau_pkg::dp_cmd_t                    cmd,
	output dau_pkg::dp_stat_t                   stat,
	input  logic [dau_pkg::KIND_W-1:0]          kind,
	input  logic [dau_pkg::YEAR_W-1:0]          year,
	input  logic [dau_pkg::MONTH_W-1:0]         month,
	input  logic [dau_pkg::DAY_W-1:0]           day,
	input  logic signed [OFFSET_BITS-1:0]       offset,
	output logic [dau_pkg::YEAR_W-1:0]          new_year,
	output logic [dau_pkg::MONTH_W-1:0]         new_month,
	output logic [dau_pkg::DAY_W-1:0]           new_day,
	output logic [dau_pkg::WD_W-1:0]            weekday,
	output logic [dau_pkg::STATUS_W-1:0]        status
);

	localparam int SW  = ((OFFSET_BITS > 20) ? OFFSET_BITS : 20) + 2;
	localparam int YW0 = $clog2(YEAR_MAX + 2);
	localparam int YW  = (YW0 > dau_pkg::YEAR_W) ? YW0 : dau_pkg::YEAR_W;
	localparam int DW0 = $clog2(YEAR_MAX * 12 + 13);
	localparam int DW  = (DW0 > dau_pkg::YEAR_W + 1) ? DW0 : dau_pkg::YEAR_W + 1;
	localparam int RW  = dau_pkg::REM_W;

	localparam logic signed [SW-1:0] S_ONE    = SW'(1);
	localparam logic signed [SW-1:0] S_TWELVE = SW'(12);
	localparam logic signed [SW-1:0] S_YMAX   = SW'(YEAR_MAX);
	localparam logic signed [SW-1:0] S_MMAX   = SW'(YEAR_MAX * 12 + 11);

	// floor(2^DW / divisor); the quotient estimate is low by at most one.
	localparam logic [DW-1:0] RCP_CENTURY =
		DW'((64'd1 << DW) / 64'(dau_pkg::DIVISOR_CENTURY));
	localparam logic [DW-1:0] RCP_MONTHS  =
		DW'((64'd1 << DW) / 64'(dau_pkg::DIVISOR_MONTHS));
	localparam logic [DW-1:0] RCP_WEEK    =
		DW'((64'd1 << DW) / 64'(dau_pkg::DIVISOR_WEEK));

	localparam logic [1:0] DIV_MUL = 2'd2;
	localparam logic [1:0] DIV_FIX = 2'd1;

	logic [dau_pkg::KIND_W-1:0]   kind_q;
	logic [dau_pkg::YEAR_W-1:0]   y_in_q;
	logic [dau_pkg::MONTH_W-1:0]  m_in_q;
	logic [dau_pkg::DAY_W-1:0]    d_in_q;
	logic signed [SW-1:0]         n_q;
	logic [YW-1:0]                ny_q;
	logic [dau_pkg::MONTH_W-1:0]  nm_q;
	logic [dau_pkg::DAY_W-1:0]    nd_q;
	logic [dau_pkg::STATUS_W-1:0] stat_q;
	logic [dau_pkg::WD_W-1:0]     wd_q;
	logic [RW-2:0]                r_q;
	logic [1:0]                   c4_q;
	logic [DW-1:0]                dvd_q;
	logic [RW-1:0]                rem_q;
	logic [RW-2:0]                dvs_q;
	logic [DW-1:0]                x_q;
	logic [DW-1:0]                rcp_q;
	logic [1:0]                   cnt_q;

	logic [dau_pkg::YEAR_W-1:0]   out_year_q;
	logic [dau_pkg::MONTH_W-1:0]  out_month_q;
	logic [dau_pkg::DAY_W-1:0]    out_day_q;
	logic [dau_pkg::WD_W-1:0]     out_wd_q;
	logic [dau_pkg::STATUS_W-1:0] out_stat_q;

	logic                         leap;
	logic [dau_pkg::DAY_W-1:0]    ml;
	logic [dau_pkg::DAY_W-1:0]    ml_prev;
	logic signed [SW-1:0]         y_ext;
	logic signed [SW-1:0]         m_ext;
	logic signed [SW-1:0]         nd_ext;
	logic signed [SW-1:0]         ml_ext;
	logic signed [SW-1:0]         t_mon;
	logic signed [SW-1:0]         t_yr;
	logic signed [SW-1:0]         sum_dn;
	logic                         fits;
	logic [YW-1:0]                wd_year;
	logic [DW-1:0]                wd_sum;
	logic                         div_start;
	logic [DW-1:0]                div_src;
	logic [RW-2:0]                div_dvs;
	logic [DW-1:0]                div_rcp;
	logic [2*DW-1:0]              prod;
	logic [DW-1:0]                rem_raw;

	always_comb begin
		leap    = ((r_q != '0) && (r_q[1:0] == 2'd0)) || ((r_q == '0) && (c4_q == 2'd0));
		ml      = dau_pkg::month_len(nm_q, leap);
		ml_prev = (nm_q == dau_pkg::MONTH_JAN) ? 5'd31 :
			dau_pkg::month_len(nm_q - 4'd1, leap);
		y_ext   = SW'(y_in_q);
		m_ext   = SW'(m_in_q);
		nd_ext  = SW'(nd_q);
		ml_ext  = SW'(ml);
		t_mon   = y_ext * S_TWELVE + m_ext - S_ONE + n_q;
		t_yr    = y_ext + n_q;
		sum_dn  = nd_ext + n_q;
		fits    = n_q[SW-1] ? (sum_dn >= S_ONE) : (sum_dn <= ml_ext);
		wd_year = (nm_q <= dau_pkg::MONTH_FEB) ? ny_q - YW'(1) : ny_q;
		// The century term -2c is replaced by +5c, which keeps the sum positive.
		wd_sum  = DW'(nd_q) + DW'(dau_pkg::zeller_term(nm_q)) + (dvd_q << 2) + dvd_q
			+ (dvd_q >> 2) + DW'(rem_q) + DW'(rem_q >> 2);
	end

	always_comb begin
		stat.div_busy = (cnt_q != '0);
		stat.date_ok  = (y_in_q != '0) && (YW'(y_in_q) <= YW'(YEAR_MAX))
			&& (m_in_q >= dau_pkg::MONTH_JAN) && (m_in_q <= dau_pkg::MONTH_DEC)
			&& (d_in_q != '0) && (d_in_q <= ml);
		stat.mon_bad  = (t_mon < S_TWELVE) || (t_mon > S_MMAX);
		stat.yr_bad   = (t_yr < S_ONE) || (t_yr > S_YMAX);
		stat.ny_bad   = (ny_q == '0) || (ny_q > YW'(YEAR_MAX));
		stat.n_zero   = (n_q == '0);
		stat.kind     = kind_q;
	end

	always_comb begin
		div_start = 1'b1;
		div_src   = DW'(ny_q);
		div_dvs   = dau_pkg::DIVISOR_CENTURY;
		div_rcp   = RCP_CENTURY;
		case (cmd.op)
			dau_pkg::OP_LOAD: begin
				div_src = DW'(year);
			end
			dau_pkg::OP_DIV_MON: begin
				div_src = DW'(t_mon);
				div_dvs = dau_pkg::DIVISOR_MONTHS;
				div_rcp = RCP_MONTHS;
			end
			dau_pkg::OP_DIV_YEAR: begin
				div_src = DW'(ny_q);
			end
			dau_pkg::OP_DIV_WDY: begin
				div_src = DW'(wd_year);
			end
			dau_pkg::OP_DIV_SUM: begin
				div_src = wd_sum;
				div_dvs = dau_pkg::DIVISOR_WEEK;
				div_rcp = RCP_WEEK;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
		prod    = {{DW{1'b0}}, x_q} * {{DW{1'b0}}, rcp_q};
		rem_raw = x_q - (dvd_q * DW'(dvs_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_start) begin
			cnt_q <= DIV_MUL;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			x_q   <= div_src;
			rcp_q <= div_rcp;
			dvs_q <= div_dvs;
		end else if (cnt_q == DIV_MUL) begin
			dvd_q <= prod[2*DW-1:DW];
		end else if (cnt_q == DIV_FIX) begin
			if (rem_raw >= DW'(dvs_q)) begin
				dvd_q <= dvd_q + DW'(1);
				rem_q <= RW'(rem_raw - DW'(dvs_q));
			end else begin
				rem_q <= RW'(rem_raw);
			end
		end

		case (cmd.op)
			dau_pkg::OP_LOAD: begin
				kind_q <= kind;
				y_in_q <= year;
				m_in_q <= month;
				d_in_q <= day;
				n_q    <= SW'(offset);
				ny_q   <= YW'(year);
				nm_q   <= month;
				nd_q   <= day;
				stat_q <= dau_pkg::STAT_OK;
			end
			dau_pkg::OP_INIT: begin
				r_q  <= rem_q[RW-2:0];
				c4_q <= dvd_q[1:0];
			end
			dau_pkg::OP_BAD: begin
				stat_q <= dau_pkg::STAT_BAD_DATE;
				wd_q   <= '0;
			end
			dau_pkg::OP_RANGE: begin
				ny_q   <= YW'(y_in_q);
				nm_q   <= m_in_q;
				nd_q   <= d_in_q;
				stat_q <= dau_pkg::STAT_RANGE;
			end
			dau_pkg::OP_YEARS: begin
				ny_q <= YW'(t_yr);
			end
			dau_pkg::OP_MONS: begin
				ny_q <= YW'(dvd_q);
				nm_q <= rem_q[dau_pkg::MONTH_W-1:0] + 4'd1;
			end
			dau_pkg::OP_CLAMP: begin
				if (nd_q > ml) begin
					nd_q <= ml;
				end
			end
			dau_pkg::OP_WALK: begin
				if (fits) begin
					nd_q <= sum_dn[dau_pkg::DAY_W-1:0];
					n_q  <= '0;
				end else if (!n_q[SW-1]) begin
					// Skip to the first day of the next month.
					n_q  <= n_q - (ml_ext - nd_ext + S_ONE);
					nd_q <= 5'd1;
					if (nm_q == dau_pkg::MONTH_DEC) begin
						nm_q <= dau_pkg::MONTH_JAN;
						ny_q <= ny_q + YW'(1);
						if (r_q == 7'd99) begin
							r_q  <= '0;
							c4_q <= c4_q + 2'd1;
						end else begin
							r_q <= r_q + 7'd1;
						end
					end else begin
						nm_q <= nm_q + 4'd1;
					end
				end else begin
					// Skip to the last day of the previous month.
					n_q  <= sum_dn;
					nd_q <= ml_prev;
					if (nm_q == dau_pkg::MONTH_JAN) begin
						nm_q <= dau_pkg::MONTH_DEC;
						ny_q <= ny_q - YW'(1);
						if (r_q == '0) begin
							r_q  <= 7'd99;
							c4_q <= c4_q - 2'd1;
						end else begin
							r_q <= r_q - 7'd1;
						end
					end else begin
						nm_q <= nm_q - 4'd1;
					end
				end
			end
			dau_pkg::OP_WD: begin
				wd_q <= rem_q[dau_pkg::WD_W-1:0];
			end
			dau_pkg::OP_PUB: begin
				out_year_q  <= ny_q[dau_pkg::YEAR_W-1:0];
				out_month_q <= nm_q;
				out_day_q   <= nd_q;
				out_wd_q    <= wd_q;
				out_stat_q  <= stat_q;
			end
			default: begin
			end
		endcase
	end

	assign new_year  = out_year_q;
	assign new_month = out_month_q;
	assign new_day   = out_day_q;
	assign weekday   = out_wd_q;
	assign status    = out_stat_q;

endmodule

[rtl/dau_ctl.sv]
// ----------------------------------------------------------------------------
// dau_ctl
// Controller: sequences the datapath through check, shift and weekday steps
// and owns both handshakes.
// ----------------------------------------------------------------------------
module dau_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dau_pkg::dp_stat_t stat,
	output dau_pkg::dp_cmd_t  cmd
);

	dau_pkg::ctl_state_t state_q;
	dau_pkg::ctl_state_t state_d;
	logic                out_valid_q;
	logic                slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == dau_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dau_pkg::ST_IDLE: begin
				if (in_valid) state_d = dau_pkg::ST_VDIV;
			end
			dau_pkg::ST_VDIV: begin
				if (!stat.div_busy) state_d = dau_pkg::ST_CHECK;
			end
			dau_pkg::ST_CHECK: begin
				if (!stat.date_ok) begin
					state_d = dau_pkg::ST_PUB;
				end else begin
					case (stat.kind)
						dau_pkg::KIND_DAYS:   state_d = dau_pkg::ST_WALK;
						dau_pkg::KIND_MONTHS: state_d = stat.mon_bad ? dau_pkg::ST_WDIV0
							: dau_pkg::ST_MDIV;
						dau_pkg::KIND_YEARS:  state_d = stat.yr_bad ? dau_pkg::ST_WDIV0
							: dau_pkg::ST_NDIV0;
						default:              state_d = dau_pkg::ST_WDIV0;
					endcase
				end
			end
			dau_pkg::ST_WALK: begin
				if (stat.ny_bad || stat.n_zero) state_d = dau_pkg::ST_WDIV0;
			end
			dau_pkg::ST_MDIV: begin
				if (!stat.div_busy) state_d = dau_pkg::ST_NDIV0;
			end
			dau_pkg::ST_NDIV0: state_d = dau_pkg::ST_NDIV;
			dau_pkg::ST_NDIV: begin
				if (!stat.div_busy) state_d = dau_pkg::ST_CLAMP;
			end
			dau_pkg::ST_CLAMP: state_d = dau_pkg::ST_WDIV0;
			dau_pkg::ST_WDIV0: state_d = dau_pkg::ST_WDIV;
			dau_pkg::ST_WDIV: begin
				if (!stat.div_busy) state_d = dau_pkg::ST_SDIV;
			end
			dau_pkg::ST_SDIV: begin
				if (!stat.div_busy) state_d = dau_pkg::ST_PUB;
			end
			dau_pkg::ST_PUB: begin
				if (slot_free) state_d = dau_pkg::ST_IDLE;
			end
			default: state_d = dau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = dau_pkg::OP_NONE;
		case (state_q)
			dau_pkg::ST_IDLE: begin
				if (in_valid) cmd.op = dau_pkg::OP_LOAD;
			end
			dau_pkg::ST_VDIV: begin
				if (!stat.div_busy) cmd.op = dau_pkg::OP_INIT;
			end
			dau_pkg::ST_CHECK: begin
				if (!stat.date_ok) begin
					cmd.op = dau_pkg::OP_BAD;
				end else begin
					case (stat.kind)
						dau_pkg::KIND_MONTHS: cmd.op = stat.mon_bad ? dau_pkg::OP_RANGE
							: dau_pkg::OP_DIV_MON;
						dau_pkg::KIND_YEARS:  cmd.op = stat.yr_bad ? dau_pkg::OP_RANGE
							: dau_pkg::OP_YEARS;
						default:              cmd.op = dau_pkg::OP_NONE;
					endcase
				end
			end
			dau_pkg::ST_WALK: begin
				if (stat.ny_bad) cmd.op = dau_pkg::OP_RANGE;
				else if (!stat.n_zero) cmd.op = dau_pkg::OP_WALK;
			end
			dau_pkg::ST_MDIV: begin
				if (!stat.div_busy) cmd.op = dau_pkg::OP_MONS;
			end
			dau_pkg::ST_NDIV0: cmd.op = dau_pkg::OP_DIV_YEAR;
			dau_pkg::ST_NDIV: begin
				if (!stat.div_busy) cmd.op = dau_pkg::OP_INIT;
			end
			dau_pkg::ST_CLAMP: cmd.op = dau_pkg::OP_CLAMP;
			dau_pkg::ST_WDIV0: cmd.op = dau_pkg::OP_DIV_WDY;
			dau_pkg::ST_WDIV: begin
				if (!stat.div_busy) cmd.op = dau_pkg::OP_DIV_SUM;
			end
			dau_pkg::ST_SDIV: begin
				if (!stat.div_busy) cmd.op = dau_pkg::OP_WD;
			end
			dau_pkg::ST_PUB: begin
				if (slot_free) cmd.op = dau_pkg::OP_PUB;
			end
			default: cmd.op = dau_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dau_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == dau_pkg::OP_PUB) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pub_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == dau_pkg::OP_PUB) |-> (!out_valid_q || out_ready))
		else $error("result published over an unconsumed result");

	a_load_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == dau_pkg::ST_VDIV))
		else $error("accepted item did not start the year check");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == dau_pkg::OP_DIV_MON) || (cmd.op == dau_pkg::OP_DIV_YEAR)
		|| (cmd.op == dau_pkg::OP_DIV_WDY) || (cmd.op == dau_pkg::OP_DIV_SUM))
		|-> !stat.div_busy)
		else $error("divider restarted while busy");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == dau_pkg::ST_PUB))
		else $error("result appeared outside the publish step");

endmodule

[rtl/date_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// date_arithmetic_unit_top
// Gregorian date shift by days, months or years, with weekday of the result.
// ----------------------------------------------------------------------------
// Each item carries a date, a signed offset and an operation kind (add days,
// add months, add years; the unused kind returns the input date). The block
// works on one item at a time. A result sits in an output register, so the
// next item is taken while that result still waits to be consumed. A shared
// divider by small constants works by operand load, reciprocal multiply and
// one correction step; it finds the century split of the year for the leap
// rule, splits a month count into years and months, and reduces the weekday
// sum modulo 7. When adding days, the walker steps one month per cycle
// until the offset is used up or the year leaves the range. The next item
// is accepted at the earliest in the cycle after the previous result is
// published; a result that still waits to be consumed holds back
// publication of the next one. An invalid input date is echoed with status
// 1 and weekday 0. A result whose year falls outside 1 to YEAR_MAX returns
// the input date, its weekday and status 2. Adding months clamps the day to
// the new month's length; adding years turns February 29 into February 28
// in a common year.
// ----------------------------------------------------------------------------
module date_arithmetic_unit_top #(
	parameter int OFFSET_BITS = dau_pkg::OFFSET_BITS_DEF,
	parameter int YEAR_MAX    = dau_pkg::YEAR_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dau_pkg::KIND_W-1:0]    kind,
	input  logic [dau_pkg::YEAR_W-1:0]    year,
	input  logic [dau_pkg::MONTH_W-1:0]   month,
	input  logic [dau_pkg::DAY_W-1:0]     day,
	input  logic signed [OFFSET_BITS-1:0] offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dau_pkg::YEAR_W-1:0]    new_year,
	output logic [dau_pkg::MONTH_W-1:0]   new_month,
	output logic [dau_pkg::DAY_W-1:0]     new_day,
	output logic [dau_pkg::WD_W-1:0]      weekday,
	output logic [dau_pkg::STATUS_W-1:0]  status
);

	// Command and status between the sequencer and the datapath.
	dau_pkg::dp_cmd_t  cmd;
	dau_pkg::dp_stat_t stat;

	dau_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the working date, the month walker and the divider.
	dau_dp #(
		.OFFSET_BITS (OFFSET_BITS),
		.YEAR_MAX    (YEAR_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (kind),
		.year      (year),
		.month     (month),
		.day       (day),
		.offset    (offset),
		.new_year  (new_year),
		.new_month (new_month),
		.new_day   (new_day),
		.weekday   (weekday),
		.status    (status)
	);

endmodule

[tb/date_arithmetic_unit_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_arithmetic_unit_top_test
// Self-checking bench for the date arithmetic unit: directed calendar corners
// and random dates are sent, and every result is compared with a calendar
// predictor kept inside the bench.
// ----------------------------------------------------------------------------
module date_arithmetic_unit_top_test;

	localparam int OFFSET_BITS = dau_pkg::OFFSET_BITS_DEF;
	localparam int YEAR_MAX    = dau_pkg::YEAR_MAX_DEF;
	localparam logic [dau_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	// One expected result item.
	typedef struct packed {
		logic [dau_pkg::YEAR_W-1:0]   y;
		logic [dau_pkg::MONTH_W-1:0]  m;
		logic [dau_pkg::DAY_W-1:0]    d;
		logic [dau_pkg::WD_W-1:0]     wd;
		logic [dau_pkg::STATUS_W-1:0] st;
	} date_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [dau_pkg::KIND_W-1:0] kind = '0;
	logic [dau_pkg::YEAR_W-1:0] year = '0;
	logic [dau_pkg::MONTH_W-1:0] month = '0;
	logic [dau_pkg::DAY_W-1:0] day = '0;
	logic signed [OFFSET_BITS-1:0] offset = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [dau_pkg::YEAR_W-1:0] new_year;
	logic [dau_pkg::MONTH_W-1:0] new_month;
	logic [dau_pkg::DAY_W-1:0] new_day;
	logic [dau_pkg::WD_W-1:0] weekday;
	logic [dau_pkg::STATUS_W-1:0] status;

	date_result_t shifted_dates[$];
	int errors = 0;
	// Idle rates in percent for the sender and the receiver.
	int send_idle = 0;
	int recv_idle = 0;

	date_arithmetic_unit_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .year(year), .month(month), .day(day), .offset(offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_year(new_year), .new_month(new_month), .new_day(new_day),
		.weekday(weekday), .status(status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Gregorian leap rule.
	function automatic bit leap_year(longint y);
		return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
	endfunction

	function automatic longint month_days(longint y, longint m);
		if (m == 2) return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		return 31;
	endfunction

	// Day number counted from March 1 of year 0.
	function automatic longint day_number(longint y, longint m, longint d);
		longint yy, era, yoe, mp, doy;
		yy = (m <= 2) ? y - 1 : y;
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic longint dow(longint y, longint m, longint k);
		longint c, s;
		if (m > 2) begin
			m -= 2;
		end else begin
			m += 10;
			y -= 1;
		end
		c = y / 100;
		y = y % 100;
		s = (k + (26 * m - 2) / 10 - 2 * c + y + y / 4 + c / 4) % 7;
		if (s < 0) s += 7;
		return s;
	endfunction

	function automatic date_result_t shift_date(logic [dau_pkg::KIND_W-1:0] k, longint y,
			longint m, longint d, longint n);
		date_result_t r;
		longint ny, nm, nd, z, era, doe, yoe, doy, mp, t, wdv;
		logic [dau_pkg::STATUS_W-1:0] st;
		ny = y; nm = m; nd = d; st = dau_pkg::STAT_OK;
		if (y < 1 || y > YEAR_MAX || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
			r.y = y[dau_pkg::YEAR_W-1:0];
			r.m = m[dau_pkg::MONTH_W-1:0];
			r.d = d[dau_pkg::DAY_W-1:0];
			r.wd = '0;
			r.st = dau_pkg::STAT_BAD_DATE;
			return r;
		end
		if (k == dau_pkg::KIND_DAYS) begin
			z = day_number(y, m, d) + n;
			if (z < day_number(1, 1, 1) || z > day_number(YEAR_MAX, 12, 31)) begin
				st = dau_pkg::STAT_RANGE;
			end else begin
				era = z / 146097;
				doe = z - era * 146097;
				yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
				doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
				mp = (5 * doy + 2) / 153;
				ny = yoe + era * 400;
				nd = doy - (153 * mp + 2) / 5 + 1;
				nm = (mp < 10) ? mp + 3 : mp - 9;
				if (nm <= 2) ny += 1;
			end
		end else if (k == dau_pkg::KIND_MONTHS) begin
			t = y * 12 + (m - 1) + n;
			if (t < 12 || t > longint'(YEAR_MAX) * 12 + 11) begin
				st = dau_pkg::STAT_RANGE;
			end else begin
				ny = t / 12;
				nm = t % 12 + 1;
				if (nd > month_days(ny, nm)) nd = month_days(ny, nm);
			end
		end else if (k == dau_pkg::KIND_YEARS) begin
			t = y + n;
			if (t < 1 || t > YEAR_MAX) begin
				st = dau_pkg::STAT_RANGE;
			end else begin
				ny = t;
				if (m == 2 && d == 29 && !leap_year(t)) nd = 28;
			end
		end
		if (st != dau_pkg::STAT_OK) begin
			ny = y; nm = m; nd = d;
		end
		wdv = dow(ny, nm, nd);
		r.y = ny[dau_pkg::YEAR_W-1:0];
		r.m = nm[dau_pkg::MONTH_W-1:0];
		r.d = nd[dau_pkg::DAY_W-1:0];
		r.wd = wdv[dau_pkg::WD_W-1:0];
		r.st = st;
		return r;
	endfunction

	// Sends one item and records its expected result once it is accepted.
	// Valid stays high after acceptance until the next idle cycle or the drain.
	task automatic send_date(logic [dau_pkg::KIND_W-1:0] k, int y, int m, int d, int n);
		logic [dau_pkg::YEAR_W-1:0] yv;
		logic [dau_pkg::MONTH_W-1:0] mv;
		logic [dau_pkg::DAY_W-1:0] dv;
		logic [OFFSET_BITS-1:0] nv;
		logic ready_seen;
		yv = y[dau_pkg::YEAR_W-1:0];
		mv = m[dau_pkg::MONTH_W-1:0];
		dv = d[dau_pkg::DAY_W-1:0];
		nv = n[OFFSET_BITS-1:0];
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		kind <= k; year <= yv; month <= mv; day <= dv; offset <= nv;
		in_valid <= 1'b1;
		// Ready only changes at rising edges, so its value at the falling edge
		// is the one that the next rising edge sees.
		forever begin
			@(negedge clk);
			ready_seen = in_ready;
			@(posedge clk);
			if (ready_seen) break;
		end
		shifted_dates.push_back(shift_date(k, longint'(yv), longint'(mv), longint'(dv),
			longint'($signed(nv))));
	endtask

	// Result checker: the handshake seen at the falling edge completes at the
	// next rising edge.
	always @(negedge clk) begin
		date_result_t want;
		if (out_valid && out_ready) begin
			if (shifted_dates.size() == 0) begin
				$display("%0t: result with nothing expected: %0d-%0d-%0d", $time,
					new_year, new_month, new_day);
				errors++;
			end else begin
				want = shifted_dates.pop_front();
				if (want.y !== new_year || want.m !== new_month || want.d !== new_day
						|| want.wd !== weekday || want.st !== status) begin
					$display("%0t: expected %0d-%0d-%0d wd %0d st %0d, got %0d-%0d-%0d wd %0d st %0d",
						$time, want.y, want.m, want.d, want.wd, want.st,
						new_year, new_month, new_day, weekday, status);
					errors++;
				end
			end
		end
	end

	// Receiver stalls.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic test_corners();
		send_date(dau_pkg::KIND_DAYS, 1, 1, 1, 0);
		send_date(dau_pkg::KIND_DAYS, 1, 1, 1, -1);
		send_date(dau_pkg::KIND_DAYS, 9999, 12, 31, 1);
		send_date(dau_pkg::KIND_DAYS, 1, 1, 1, 32767);
		send_date(dau_pkg::KIND_DAYS, 9999, 12, 31, -32768);
		send_date(dau_pkg::KIND_DAYS, 2000, 2, 28, 1);
		send_date(dau_pkg::KIND_DAYS, 1900, 2, 28, 1);
		send_date(dau_pkg::KIND_MONTHS, 2024, 1, 31, 1);
		send_date(dau_pkg::KIND_MONTHS, 2023, 1, 31, 1);
		send_date(dau_pkg::KIND_MONTHS, 2024, 12, 15, 1);
		send_date(dau_pkg::KIND_MONTHS, 1, 1, 1, -1);
		send_date(dau_pkg::KIND_MONTHS, 9999, 12, 1, 1);
		send_date(dau_pkg::KIND_MONTHS, 5000, 6, 30, -32768);
		send_date(dau_pkg::KIND_YEARS, 2024, 2, 29, 1);
		send_date(dau_pkg::KIND_YEARS, 2024, 2, 29, 4);
		send_date(dau_pkg::KIND_YEARS, 1, 5, 5, 9998);
		send_date(dau_pkg::KIND_YEARS, 1, 5, 5, 9999);
		send_date(dau_pkg::KIND_YEARS, 100, 5, 5, -32768);
		send_date(KIND_UNUSED, 1234, 5, 6, 32767);
		// Invalid input dates: zero fields, too large fields, day past month end.
		send_date(dau_pkg::KIND_DAYS, 0, 1, 1, 1);
		send_date(dau_pkg::KIND_MONTHS, 16383, 15, 31, 1);
		send_date(dau_pkg::KIND_YEARS, 2023, 2, 29, 1);
		send_date(dau_pkg::KIND_DAYS, 2023, 0, 0, 1);
		send_date(dau_pkg::KIND_DAYS, 2023, 4, 31, 1);
	endtask

	task automatic test_random(int count);
		logic [dau_pkg::KIND_W-1:0] k;
		int kv, y, m, d, n;
		repeat (count) begin
			kv = int'($urandom_range(2));
			k = ($urandom_range(9) == 0) ? KIND_UNUSED : kv[dau_pkg::KIND_W-1:0];
			y = int'($urandom_range(1, YEAR_MAX));
			m = int'($urandom_range(1, 12));
			d = int'($urandom_range(1, int'(month_days(longint'(y), longint'(m)))));
			case ($urandom_range(9))
				0: n = int'($urandom);
				1, 2: n = int'($urandom_range(0, 4000)) - 2000;
				3: n = int'($urandom_range(0, 40)) - 20;
				default: n = int'($urandom_range(0, 1000)) - 500;
			endcase
			if ($urandom_range(19) == 0) begin
				y = int'($urandom);
				m = int'($urandom);
				d = int'($urandom);
			end
			send_date(k, y, m, d, n);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (shifted_dates.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 20;
		recv_idle = 62;
		test_corners();
		test_random(170);
		send_idle = 62;
		recv_idle = 20;
		test_random(170);
		send_idle = 0;
		recv_idle = 0;
		test_random(175);
		drain();
		if (errors == 0 && shifted_dates.size() == 0) begin
			$display("PASS date_arithmetic_unit_top");
		end else begin
			$display("FAIL date_arithmetic_unit_top");
		end
		$finish;
	end

	// Timeout guard; it is ample for the worst case item with stalls.
	initial begin
		#20ms;
		$display("FAIL date_arithmetic_unit_top");
		$finish;
	end

endmodule

[files.f]
rtl/dau_pkg.sv
rtl/dau_dp.sv
rtl/dau_ctl.sv
rtl/date_arithmetic_unit_top.sv
tb/date_arithmetic_unit_top_test.sv
